### hw/rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// shared types and constants of the timed event queue
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned TIME_W      = 31;
    localparam int unsigned HANDLE_W    = 16;
    localparam int unsigned GROUP_W     = 16;
    localparam int unsigned ORDER_W     = 32;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_REGISTER     = 2'd0,
        OP_DEREGISTER   = 2'd1,
        OP_REMOVE_GROUP = 2'd2,
        OP_PROCESS      = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_FLUSH,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]   due;
        logic [HANDLE_W-1:0] handle;
        logic [GROUP_W-1:0]  group;
        logic [ORDER_W-1:0]  order;
    } t_entry;

endpackage

### hw/rtl/teq_if.sv
// ----------------------------------------------------------------------------
// teq_if
// command and result channels of the timed event queue
// ----------------------------------------------------------------------------
interface teq_cmd_if;
    import teq_pkg::*;

    logic                valid;
    logic                ready;
    t_opcode             opcode;
    logic [TIME_W-1:0]   now_ms;
    logic [HANDLE_W-1:0] command_handle;
    logic [GROUP_W-1:0]  group_id;
    logic [TIME_W-1:0]   delay_ms;

    modport source (
        output valid, opcode, now_ms, command_handle, group_id, delay_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_ms, command_handle, group_id, delay_ms,
        output ready
    );
endinterface

interface teq_res_if;
    import teq_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic                fired;
    logic [HANDLE_W-1:0] fired_handle;
    logic                last;

    modport source (
        output valid, status, fired, fired_handle, last,
        input  ready
    );
    modport sink (
        input  valid, status, fired, fired_handle, last,
        output ready
    );
endinterface

### hw/rtl/timed_event_queue_top.sv
// ----------------------------------------------------------------------------
// timed_event_queue_top
// table of pending timed commands: register, deregister, remove group, process
// ----------------------------------------------------------------------------
// One command word is taken at a time; ready stays low until its last result
// word has been placed in the output register. Entries live in a single-port
// read / single-port write ram with per-entry valid flops, so no clearing pass
// follows reset. Register searches the valid flops for the lowest free slot,
// one slot a cycle. Deregister and remove group sweep the entry ram through
// its one read port. Process sweeps the whole ram once per fired entry to
// pick the earliest due one (ties by insertion order), with at most
// MAX_RESULTS entries fired per command.
// ----------------------------------------------------------------------------
module timed_event_queue_top #(
    parameter int unsigned TABLE_DEPTH = teq_pkg::TABLE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    teq_cmd_if.sink  i_cmd,
    teq_res_if.source o_res
);
    import teq_pkg::*;

    localparam int unsigned       IDX_W    = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_RESULTS);

    t_state                  r_state, n_state;
    t_state                  r_after, n_after;
    logic [TABLE_DEPTH-1:0]  r_valid, n_valid;
    logic [ORDER_W-1:0]      r_order_ctr, n_order_ctr;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    r_issuing, n_issuing;
    logic                    r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]        r_cmp_idx, n_cmp_idx;
    logic                    r_best_vld, n_best_vld;
    logic [IDX_W-1:0]        r_best_idx, n_best_idx;
    logic [TIME_W-1:0]       r_best_due, n_best_due;
    logic [ORDER_W-1:0]      r_best_order, n_best_order;
    logic [HANDLE_W-1:0]     r_best_handle, n_best_handle;
    logic                    r_pend_vld, n_pend_vld;
    logic [HANDLE_W-1:0]     r_pend_handle, n_pend_handle;
    logic [CNT_W-1:0]        r_count, n_count;

    t_opcode                 r_op, n_op;
    logic [TIME_W-1:0]       r_now, n_now;
    logic [HANDLE_W-1:0]     r_handle, n_handle;
    logic [GROUP_W-1:0]      r_group, n_group;
    logic [TIME_W-1:0]       r_due, n_due;

    t_status                 r_res_status, n_res_status;
    logic                    r_res_fired, n_res_fired;
    logic [HANDLE_W-1:0]     r_res_handle, n_res_handle;
    logic                    r_res_last, n_res_last;

    logic                    r_out_vld, n_out_vld;
    t_status                 r_out_status, n_out_status;
    logic                    r_out_fired, n_out_fired;
    logic [HANDLE_W-1:0]     r_out_handle, n_out_handle;
    logic                    r_out_last, n_out_last;

    logic                    ram_we;
    t_entry                  wr_entry;
    t_entry                  rd_entry;
    logic [$bits(t_entry)-1:0] ram_rd_data;

    logic                    cmp_live;
    logic                    take;
    logic                    scan_end;
    logic                    cur_vld;
    logic [IDX_W-1:0]        cur_idx;
    logic [HANDLE_W-1:0]     cur_handle;
    logic [CNT_W-1:0]        cnt_new;
    logic [TIME_W:0]         due_sum;
    logic                    out_free;

    teq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_teq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    assign rd_entry = t_entry'(ram_rd_data);

    assign wr_entry.due    = r_due;
    assign wr_entry.handle = r_handle;
    assign wr_entry.group  = r_group;
    assign wr_entry.order  = r_order_ctr;

    // compare stage on the word read out of the ram
    assign cmp_live = r_cmp_vld && r_valid[r_cmp_idx];
    assign take     = (r_op == OP_PROCESS) && cmp_live && (rd_entry.due <= r_now) &&
                      (!r_best_vld || (rd_entry.due < r_best_due) ||
                       ((rd_entry.due == r_best_due) && (rd_entry.order < r_best_order)));
    assign scan_end   = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign cur_vld    = r_best_vld || take;
    assign cur_idx    = take ? r_cmp_idx : r_best_idx;
    assign cur_handle = take ? rd_entry.handle : r_best_handle;
    assign cnt_new    = r_count + CNT_W'(1);

    assign due_sum  = {1'b0, i_cmd.now_ms} + {1'b0, i_cmd.delay_ms};
    assign out_free = !r_out_vld || o_res.ready;

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_vld;
    assign o_res.status       = r_out_status;
    assign o_res.fired        = r_out_fired;
    assign o_res.fired_handle = r_out_handle;
    assign o_res.last         = r_out_last;

    always_comb begin
        n_state       = r_state;
        n_after       = r_after;
        n_valid       = r_valid;
        n_order_ctr   = r_order_ctr;
        n_idx         = r_idx;
        n_issuing     = r_issuing;
        n_cmp_vld     = 1'b0;
        n_cmp_idx     = r_idx;
        n_best_vld    = r_best_vld;
        n_best_idx    = r_best_idx;
        n_best_due    = r_best_due;
        n_best_order  = r_best_order;
        n_best_handle = r_best_handle;
        n_pend_vld    = r_pend_vld;
        n_pend_handle = r_pend_handle;
        n_count       = r_count;
        n_op          = r_op;
        n_now         = r_now;
        n_handle      = r_handle;
        n_group       = r_group;
        n_due         = r_due;
        n_res_status  = r_res_status;
        n_res_fired   = r_res_fired;
        n_res_handle  = r_res_handle;
        n_res_last    = r_res_last;
        n_out_vld     = r_out_vld && !o_res.ready;
        n_out_status  = r_out_status;
        n_out_fired   = r_out_fired;
        n_out_handle  = r_out_handle;
        n_out_last    = r_out_last;
        ram_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op       = i_cmd.opcode;
                    n_now      = i_cmd.now_ms;
                    n_handle   = i_cmd.command_handle;
                    n_group    = i_cmd.group_id;
                    if (i_cmd.delay_ms == '0) begin
                        n_due = '0;
                    end else if (due_sum[TIME_W]) begin
                        n_due = '1;
                    end else begin
                        n_due = due_sum[TIME_W-1:0];
                    end
                    n_idx      = '0;
                    n_issuing  = 1'b1;
                    n_best_vld = 1'b0;
                    n_pend_vld = 1'b0;
                    n_count    = '0;
                    n_state    = (i_cmd.opcode == OP_REGISTER) ? S_FREE : S_SCAN;
                end
            end
            S_FREE: begin
                n_res_fired  = 1'b0;
                n_res_handle = '0;
                n_res_last   = 1'b1;
                n_after      = S_IDLE;
                if (!r_valid[r_idx]) begin
                    ram_we         = 1'b1;
                    n_valid[r_idx] = 1'b1;
                    n_order_ctr    = r_order_ctr + ORDER_W'(1);
                    n_res_status   = ST_OK;
                    n_state        = S_RESP;
                end else if (r_idx == LAST_IDX) begin
                    n_res_status = ST_FULL;
                    n_state      = S_RESP;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SCAN: begin
                if (r_issuing) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx;
                    n_idx     = r_idx + IDX_W'(1);
                    n_issuing = (r_idx != LAST_IDX);
                end
                n_res_fired  = 1'b0;
                n_res_handle = '0;
                n_res_last   = 1'b1;
                n_res_status = ST_OK;
                n_after      = S_IDLE;
                case (r_op)
                    OP_DEREGISTER: begin
                        if (cmp_live && (rd_entry.handle == r_handle)) begin
                            n_valid[r_cmp_idx] = 1'b0;
                            n_cmp_vld = 1'b0;
                            n_issuing = 1'b0;
                            n_state   = S_RESP;
                        end else if (scan_end) begin
                            n_res_status = ST_NOT_FOUND;
                            n_state      = S_RESP;
                        end
                    end
                    OP_REMOVE_GROUP: begin
                        if (cmp_live && (rd_entry.group == r_group)) begin
                            n_valid[r_cmp_idx] = 1'b0;
                        end
                        if (scan_end) begin
                            n_state = S_RESP;
                        end
                    end
                    OP_PROCESS: begin
                        if (take) begin
                            n_best_vld    = 1'b1;
                            n_best_idx    = r_cmp_idx;
                            n_best_due    = rd_entry.due;
                            n_best_order  = rd_entry.order;
                            n_best_handle = rd_entry.handle;
                        end
                        if (scan_end) begin
                            if (cur_vld) begin
                                n_valid[cur_idx] = 1'b0;
                                n_count       = cnt_new;
                                n_pend_vld    = 1'b1;
                                n_pend_handle = cur_handle;
                                n_idx         = '0;
                                n_issuing     = 1'b1;
                                n_best_vld    = 1'b0;
                                if (r_pend_vld) begin
                                    n_res_fired  = 1'b1;
                                    n_res_handle = r_pend_handle;
                                    n_res_last   = 1'b0;
                                    n_after      = (cnt_new == CNT_MAX) ? S_FLUSH : S_SCAN;
                                    n_state      = S_RESP;
                                end else if (cnt_new == CNT_MAX) begin
                                    n_state = S_FLUSH;
                                end
                            end else begin
                                n_res_fired  = r_pend_vld;
                                n_res_handle = r_pend_vld ? r_pend_handle : '0;
                                n_state      = S_RESP;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FLUSH: begin
                n_res_status = ST_OK;
                n_res_fired  = 1'b1;
                n_res_handle = r_pend_handle;
                n_res_last   = 1'b1;
                n_after      = S_IDLE;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_fired  = r_res_fired;
                    n_out_handle = r_res_handle;
                    n_out_last   = r_res_last;
                    n_state      = r_after;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_valid     <= '0;
            r_order_ctr <= '0;
            r_issuing   <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_best_vld  <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_count     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_valid     <= n_valid;
            r_order_ctr <= n_order_ctr;
            r_issuing   <= n_issuing;
            r_cmp_vld   <= n_cmp_vld;
            r_best_vld  <= n_best_vld;
            r_pend_vld  <= n_pend_vld;
            r_count     <= n_count;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_best_idx    <= n_best_idx;
        r_best_due    <= n_best_due;
        r_best_order  <= n_best_order;
        r_best_handle <= n_best_handle;
        r_pend_handle <= n_pend_handle;
        r_op          <= n_op;
        r_now         <= n_now;
        r_handle      <= n_handle;
        r_group       <= n_group;
        r_due         <= n_due;
        r_res_status  <= n_res_status;
        r_res_fired   <= n_res_fired;
        r_res_handle  <= n_res_handle;
        r_res_last    <= n_res_last;
        r_out_status  <= n_out_status;
        r_out_fired   <= n_out_fired;
        r_out_handle  <= n_out_handle;
        r_out_last    <= n_out_last;
    end
endmodule

### hw/rtl/teq_ram.sv
// ----------------------------------------------------------------------------
// teq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module teq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

### hw/rtl/teq_checker.sv
// ----------------------------------------------------------------------------
// teq_checker
// port-level checks of the timed event queue, bound to the top level
// ----------------------------------------------------------------------------
module teq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_status,
    input logic       i_out_fired,
    input logic       i_out_last
);
    import teq_pkg::*;

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before handoff");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    // one command word in flight at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command word taken while busy");

    // a word without a fired entry always closes its command
    a_nofire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_fired || i_out_last))
        else $error("non-fired result word without last");

    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_fired |-> (i_out_status == ST_OK))
        else $error("fired result word with error status");
endmodule

bind timed_event_queue_top teq_checker u_teq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_status (o_res.status),
    .i_out_fired  (o_res.fired),
    .i_out_last   (o_res.last)
);

### tb/timed_event_queue_top_tb.sv
// ----------------------------------------------------------------------------
// timed_event_queue_top_tb
// self-checking bench for the timed event queue
// ----------------------------------------------------------------------------
// A queue of command words, filled by the stimulus process, feeds a clocked
// driver. The driver mirrors each accepted command into a shadow copy of the
// entry table and queues the result words it should produce. A clocked
// monitor pops the oldest queued word for every accepted result and compares
// it field by field. The run starts with directed corner cases: empty table,
// handle not found, saturated due times, ties, duplicate handles, a full
// table, group removal and the time boundary of process. Four random phases
// follow, each with its own sender and receiver idle rates. Each phase opens
// with a sixteen entry burst, then mixes commands over small handle and
// group pools with some fully random words.
// ----------------------------------------------------------------------------
module timed_event_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import teq_pkg::*;

    typedef struct {
        t_opcode             op;
        logic [TIME_W-1:0]   now;
        logic [HANDLE_W-1:0] handle;
        logic [GROUP_W-1:0]  group;
        logic [TIME_W-1:0]   delay;
    } t_cmd_word;

    typedef struct {
        t_status             status;
        logic                fired;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } t_res_word;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int unsigned TAIL_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    teq_cmd_if cmd_bus ();
    teq_res_if res_bus ();

    timed_event_queue_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_cmd_word pending_cmds[$];
    t_res_word expected_words[$];
    t_cmd_word in_flight;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        error_count = 0;

    // shadow of the entry table
    logic                tbl_used [TABLE_DEPTH];
    logic [TIME_W-1:0]   tbl_due  [TABLE_DEPTH];
    logic [HANDLE_W-1:0] tbl_handle [TABLE_DEPTH];
    logic [GROUP_W-1:0]  tbl_group  [TABLE_DEPTH];
    logic [ORDER_W-1:0]  tbl_seq  [TABLE_DEPTH];
    logic [ORDER_W-1:0]  seq_next;

    logic [TIME_W-1:0]   now_base;
    logic [HANDLE_W-1:0] handle_pool [8];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_word(input t_status st, input logic fired,
                             input logic [HANDLE_W-1:0] h, input logic last);
        t_res_word w;
        w.status = st;
        w.fired  = fired;
        w.handle = h;
        w.last   = last;
        expected_words.push_back(w);
    endtask

    task automatic apply_command(input t_cmd_word c);
        int                  slot;
        int                  best;
        logic [31:0]         sum;
        logic [HANDLE_W-1:0] fired_q[$];
        case (c.op)
            OP_REGISTER: begin
                slot = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (!tbl_used[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    push_word(ST_FULL, 1'b0, '0, 1'b1);
                end else begin
                    sum = {1'b0, c.now} + {1'b0, c.delay};
                    tbl_used[slot]   = 1'b1;
                    tbl_due[slot]    = (c.delay == '0) ? '0 :
                                       (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
                    tbl_handle[slot] = c.handle;
                    tbl_group[slot]  = c.group;
                    tbl_seq[slot]    = seq_next;
                    seq_next         = seq_next + 1;
                    push_word(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            OP_DEREGISTER: begin
                slot = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (tbl_used[i] && tbl_handle[i] == c.handle && slot < 0) slot = i;
                if (slot < 0) begin
                    push_word(ST_NOT_FOUND, 1'b0, '0, 1'b1);
                end else begin
                    tbl_used[slot] = 1'b0;
                    push_word(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            OP_REMOVE_GROUP: begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (tbl_used[i] && tbl_group[i] == c.group) tbl_used[i] = 1'b0;
                push_word(ST_OK, 1'b0, '0, 1'b1);
            end
            default: begin
                best = 0;
                while (fired_q.size() < MAX_RESULTS && best >= 0) begin
                    best = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (tbl_used[i] && tbl_due[i] <= c.now) begin
                            if (best < 0 || tbl_due[i] < tbl_due[best] ||
                                (tbl_due[i] == tbl_due[best] && tbl_seq[i] < tbl_seq[best]))
                                best = i;
                        end
                    end
                    if (best >= 0) begin
                        tbl_used[best] = 1'b0;
                        fired_q.push_back(tbl_handle[best]);
                    end
                end
                if (fired_q.size() == 0) begin
                    push_word(ST_OK, 1'b0, '0, 1'b1);
                end else begin
                    foreach (fired_q[k])
                        push_word(ST_OK, 1'b1, fired_q[k], k == fired_q.size() - 1);
                end
            end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) apply_command(in_flight);
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_flight              = pending_cmds.pop_front();
                    cmd_bus.valid          <= 1'b1;
                    cmd_bus.opcode         <= in_flight.op;
                    cmd_bus.now_ms         <= in_flight.now;
                    cmd_bus.command_handle <= in_flight.handle;
                    cmd_bus.group_id       <= in_flight.group;
                    cmd_bus.delay_ms       <= in_flight.delay;
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_res_word want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word status=%0d fired=%0b handle=%h last=%0b",
                                              res_bus.status, res_bus.fired,
                                              res_bus.fired_handle, res_bus.last));
                end else begin
                    want = expected_words.pop_front();
                    if (res_bus.status !== want.status || res_bus.fired !== want.fired ||
                        res_bus.fired_handle !== want.handle || res_bus.last !== want.last)
                        report_mismatch($sformatf(
                            "got status=%0d fired=%0b handle=%h last=%0b, want %0d %0b %h %0b",
                            res_bus.status, res_bus.fired, res_bus.fired_handle, res_bus.last,
                            want.status, want.fired, want.handle, want.last));
                end
            end
            res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_cmd(input t_opcode op, input logic [TIME_W-1:0] now,
                            input logic [HANDLE_W-1:0] h, input logic [GROUP_W-1:0] g,
                            input logic [TIME_W-1:0] delay);
        t_cmd_word c;
        c.op     = op;
        c.now    = now;
        c.handle = h;
        c.group  = g;
        c.delay  = delay;
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || cmd_bus.valid || expected_words.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic push_burst();
        push_cmd(OP_PROCESS, TIME_MAX, HANDLE_W'($urandom()), GROUP_W'($urandom()),
                 TIME_W'($urandom()));
        for (int k = 0; k < TABLE_DEPTH; k++)
            push_cmd(OP_REGISTER, now_base, handle_pool[$urandom_range(0, 7)],
                     GROUP_W'($urandom_range(0, 3)),
                     ($urandom_range(0, 1) == 0) ? '0 : TIME_W'($urandom_range(1, 5)));
        push_cmd(OP_PROCESS, TIME_MAX, HANDLE_W'($urandom()), GROUP_W'($urandom()),
                 TIME_W'($urandom()));
    endtask

    task automatic push_random_cmd();
        int                  r;
        logic [HANDLE_W-1:0] h;
        logic [GROUP_W-1:0]  g;
        logic [TIME_W-1:0]   d;
        r = $urandom_range(0, 99);
        if (r < 5) now_base = TIME_W'($urandom());
        else if (r < 8) now_base = TIME_W'($urandom_range(32'h7FFFFFFF, 32'h7FFFFC00));
        else now_base = now_base + TIME_W'($urandom_range(0, 50));
        h = ($urandom_range(0, 9) < 8) ? handle_pool[$urandom_range(0, 7)] :
                                         HANDLE_W'($urandom());
        g = ($urandom_range(0, 9) < 8) ? GROUP_W'($urandom_range(0, 3)) : GROUP_W'($urandom());
        r = $urandom_range(0, 99);
        if (r < 15) d = '0;
        else if (r < 75) d = TIME_W'($urandom_range(1, 200));
        else if (r < 90) d = TIME_W'($urandom());
        else d = TIME_W'($urandom_range(32'h7FFFFFFF, 32'h7FFFF000));
        r = $urandom_range(0, 99);
        if (r < 10)
            push_cmd(t_opcode'($urandom_range(0, 3)), TIME_W'($urandom()),
                     HANDLE_W'($urandom()), GROUP_W'($urandom()), TIME_W'($urandom()));
        else if (r < 50) push_cmd(OP_REGISTER, now_base, h, GROUP_W'($urandom()), d);
        else if (r < 64) push_cmd(OP_DEREGISTER, now_base, h, GROUP_W'($urandom()),
                                  TIME_W'($urandom()));
        else if (r < 72) push_cmd(OP_REMOVE_GROUP, now_base, HANDLE_W'($urandom()), g,
                                  TIME_W'($urandom()));
        else push_cmd(OP_PROCESS,
                      ($urandom_range(0, 9) == 0) ? TIME_W'($urandom()) : now_base,
                      HANDLE_W'($urandom()), GROUP_W'($urandom()), TIME_W'($urandom()));
    endtask

    initial begin
        i_rst_n = 1'b0;
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        seq_next = '0;
        now_base = '0;
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        for (int i = 2; i < 8; i++) handle_pool[i] = HANDLE_W'($urandom());
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        push_cmd(OP_PROCESS, '0, '0, '0, '0);
        push_cmd(OP_DEREGISTER, '0, 16'hFFFF, '0, '0);
        push_cmd(OP_REGISTER, TIME_MAX, 16'h0000, 16'h0000, '0);
        push_cmd(OP_REGISTER, TIME_MAX, 16'hFFFF, 16'hFFFF, TIME_MAX);
        push_cmd(OP_REGISTER, 31'd100, 16'h1234, 16'h0001, 31'd50);
        push_cmd(OP_REGISTER, 31'd100, 16'h1234, 16'h0001, 31'd50);
        push_cmd(OP_REGISTER, 31'd0, 16'h0001, 16'h0002, 31'd150);
        for (int k = 0; k < 11; k++)
            push_cmd(OP_REGISTER, 31'd1000, HANDLE_W'(16'h0100 + k), 16'h0003,
                     TIME_W'(k + 1));
        push_cmd(OP_REGISTER, 31'd0, 16'hABCD, 16'h0003, 31'd1);
        push_cmd(OP_DEREGISTER, '0, 16'h1234, '0, '0);
        push_cmd(OP_REMOVE_GROUP, '0, '0, 16'h0003, '0);
        push_cmd(OP_PROCESS, TIME_MAX - 31'd1, '0, '0, '0);
        push_cmd(OP_PROCESS, TIME_MAX, '0, '0, '0);
        push_cmd(OP_PROCESS, TIME_MAX, '0, '0, '0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            push_burst();
            for (int k = 0; k < 44; k++) push_random_cmd();
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("PASS timed_event_queue_top");
        else
            $display("FAIL timed_event_queue_top");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL timed_event_queue_top");
        $finish;
    end

endmodule
